FILE: hw/rtl/fpam_pkg.sv
// shared types, op codes and the sequencer program for the affine matrix unit
// no dependencies
package fpam_pkg;

	localparam int WORD_W        = 32;
	localparam int IDX_W         = 4;
	localparam int ELEMS         = 12;
	localparam int FRAC_BITS_DEF = 12;

	// op codes of an input beat
	localparam logic [2:0] OP_LOAD_L   = 3'd0;
	localparam logic [2:0] OP_LOAD_R   = 3'd1;
	localparam logic [2:0] OP_COMPOSE  = 3'd2;
	localparam logic [2:0] OP_XFORM    = 3'd3;
	localparam logic [2:0] OP_IDENTITY = 3'd4;

	// program layout
	localparam int XF_BASE   = 0;
	localparam int CM_BASE   = 9;
	localparam int ROM_DEPTH = 48;
	localparam int PC_W      = $clog2(ROM_DEPTH);

	// second multiplier operand
	typedef enum logic [1:0] {
		QS_RIGHT,
		QS_VX,
		QS_VY,
		QS_VZ
	} qsel_t;

	// one control word
	typedef struct packed {
		logic [IDX_W-1:0] la;    // left matrix read address
		logic [IDX_W-1:0] rb;    // right matrix read address
		qsel_t            qsel;
		logic             first; // clear accumulator
		logic             bias;  // pass left word as bias, no product
		logic             emit;  // word complete after this step
		logic             wb;    // word goes back into left matrix
		logic [IDX_W-1:0] oidx;
		logic             last;
		logic             stop;  // final step of the routine
	} ctl_t;

	typedef ctl_t [ROM_DEPTH-1:0] rom_t;

	function automatic rom_t build_rom();
		rom_t rom;
		int   s;
		rom = '0;
		// vector transform: three words, three products each
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				s = XF_BASE + c * 3 + k;
				rom[s].la    = IDX_W'(k * 3 + c);
				rom[s].qsel  = qsel_t'(2'(k + 1));
				rom[s].first = (k == 0);
				rom[s].emit  = (k == 2);
				rom[s].oidx  = IDX_W'(c);
				rom[s].last  = (c == 2) && (k == 2);
				rom[s].stop  = (c == 2) && (k == 2);
			end
		end
		// compose, rotation part
		for (int w = 0; w < 9; w++) begin
			for (int k = 0; k < 3; k++) begin
				s = CM_BASE + w * 3 + k;
				rom[s].la    = IDX_W'((w / 3) * 3 + k);
				rom[s].rb    = IDX_W'(k * 3 + (w % 3));
				rom[s].qsel  = QS_RIGHT;
				rom[s].first = (k == 0);
				rom[s].emit  = (k == 2);
				rom[s].wb    = 1'b1;
				rom[s].oidx  = IDX_W'(w);
			end
		end
		// compose, translation: three products then the old translation word
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 4; k++) begin
				s = CM_BASE + 27 + c * 4 + k;
				rom[s].qsel  = QS_RIGHT;
				rom[s].wb    = 1'b1;
				rom[s].oidx  = IDX_W'(9 + c);
				rom[s].first = (k == 0);
				if (k < 3) begin
					rom[s].la = IDX_W'(k * 3 + c);
					rom[s].rb = IDX_W'(9 + k);
				end else begin
					rom[s].la   = IDX_W'(9 + c);
					rom[s].bias = 1'b1;
					rom[s].emit = 1'b1;
					rom[s].last = (c == 2);
					rom[s].stop = (c == 2);
				end
			end
		end
		return rom;
	endfunction

	localparam rom_t PROGRAM = build_rom();

endpackage

FILE: hw/rtl/fpam_seq.sv
// microcode sequencer: step counter over the program table
// depends on fpam_pkg
module fpam_seq import fpam_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] op,
	input  logic       adv,
	output logic       running,
	output ctl_t       ctl
);

	logic            running_q;
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] start_pc;

	always_comb begin
		if (op == OP_COMPOSE) begin
			start_pc = PC_W'(CM_BASE);
		end else begin
			start_pc = PC_W'(XF_BASE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pc_q      <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			pc_q      <= start_pc;
		end else if (running_q && adv) begin
			if (PROGRAM[pc_q].stop) begin
				running_q <= 1'b0;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	assign running = running_q;
	assign ctl     = PROGRAM[pc_q];

endmodule

FILE: hw/rtl/fixed_point_affine_matrix_unit.sv
// top level of the q-format 3x4 affine matrix unit: matrix storage, one shared
// multiply-accumulate datapath and the output register
// depends on fpam_pkg and fpam_seq
//
// channel | dir | handshake          | beat payload
// --------+-----+--------------------+-----------------------------------------
// in      | in  | in_valid/in_stall  | op, index, value, vec_x, vec_y, vec_z
// out     | out | out_valid/out_stall| out_index, out_value, last
//
// loads and identity finish in the cycle they are accepted and give no beat
// a transform issues 9 multiply steps (one product per cycle, unless the output
// stalls, through the single 32x32 multiplier) and blocks input until its last
// beat has reached the output register; a compose issues 39 steps (27 rotation
// products, 9 translation products and 3 bias steps) and blocks input likewise
// reset clears both matrices and the sequencer at once, no sweep
// a stalled output freezes the sequencer and the whole datapath; input stays
// stalled until every beat of the running item has reached the output register
module fixed_point_affine_matrix_unit import fpam_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               op,
	input  logic [IDX_W-1:0]         index,
	input  logic signed [WORD_W-1:0] value,
	input  logic signed [WORD_W-1:0] vec_x,
	input  logic signed [WORD_W-1:0] vec_y,
	input  logic signed [WORD_W-1:0] vec_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IDX_W-1:0]         out_index,
	output logic signed [WORD_W-1:0] out_value,
	output logic                     last
);

	// matrix storage, flops read at one sequencer-chosen address each
	logic [WORD_W-1:0] l_q [ELEMS];
	logic [WORD_W-1:0] r_q [ELEMS];
	// compose result buffer, copied into the left matrix with the last word
	logic [WORD_W-1:0] t_q [ELEMS];
	logic [WORD_W-1:0] vx_q, vy_q, vz_q;

	logic accept;
	logic en;
	logic running;
	ctl_t ctl;

	// stage 1: product or bias word
	logic              v_s1;
	ctl_t              ctl_s1;
	logic [WORD_W-1:0] data_s1;

	// stage 2: accumulator
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] bias_q;
	logic              fire_s2;
	logic              wb_s2;
	logic              last_s2;
	logic [IDX_W-1:0]  oidx_s2;

	// output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [WORD_W-1:0] out_value_q;
	logic              out_last_q;

	logic [WORD_W-1:0] p_rd;
	logic [WORD_W-1:0] q_rd;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] res;

	// whole datapath holds while a finished beat waits at the output
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = running || v_s1 || fire_s2;
	assign accept   = in_valid && !in_stall;

	fpam_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && (op == OP_COMPOSE || op == OP_XFORM)),
		.op      (op),
		.adv     (en),
		.running (running),
		.ctl     (ctl)
	);

	// operand fetch and multiply
	assign p_rd = l_q[ctl.la];

	always_comb begin
		unique case (ctl.qsel)
			QS_RIGHT: q_rd = r_q[ctl.rb];
			QS_VX:    q_rd = vx_q;
			QS_VY:    q_rd = vy_q;
			QS_VZ:    q_rd = vz_q;
			default:  q_rd = r_q[ctl.rb];
		endcase
	end

	// low word of the product is the same for signed and unsigned operands
	assign prod = p_rd * q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= running;
		end
	end

	always_ff @(posedge clk) begin
		if (en && running) begin
			ctl_s1  <= ctl;
			data_s1 <= ctl.bias ? p_rd : prod;
		end
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			if (ctl_s1.bias) begin
				bias_q <= data_s1;
			end else begin
				acc_q <= (ctl_s1.first ? '0 : acc_q) + data_s1;
				if (ctl_s1.emit) begin
					bias_q <= '0;
				end
			end
			oidx_s2 <= ctl_s1.oidx;
			last_s2 <= ctl_s1.last;
			wb_s2   <= ctl_s1.wb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_s2 <= 1'b0;
		end else if (en) begin
			fire_s2 <= v_s1 && ctl_s1.emit;
		end
	end

	// arithmetic shift rounds toward minus infinity, then the bias word
	assign res = WORD_W'($signed(acc_q) >>> FRAC_BITS) + bias_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= fire_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && fire_s2) begin
			out_index_q <= oidx_s2;
			out_value_q <= res;
			out_last_q  <= last_s2;
		end
	end

	// compose buffer
	always_ff @(posedge clk) begin
		if (en && fire_s2 && wb_s2) begin
			t_q[oidx_s2] <= res;
		end
	end

	// vector operands, held for the whole transform
	always_ff @(posedge clk) begin
		if (accept && op == OP_XFORM) begin
			vx_q <= vec_x;
			vy_q <= vec_y;
			vz_q <= vec_z;
		end
	end

	// right matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ELEMS; i++) begin
				r_q[i] <= '0;
			end
		end else if (accept && op == OP_LOAD_R && index < IDX_W'(ELEMS)) begin
			r_q[index] <= value;
		end
	end

	// left matrix: loads, identity, compose write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ELEMS; i++) begin
				l_q[i] <= '0;
			end
		end else if (en && fire_s2 && wb_s2 && last_s2) begin
			for (int i = 0; i < ELEMS; i++) begin
				l_q[i] <= (IDX_W'(i) == oidx_s2) ? res : t_q[i];
			end
		end else if (accept) begin
			if (op == OP_LOAD_L && index < IDX_W'(ELEMS)) begin
				l_q[index] <= value;
			end else if (op == OP_IDENTITY) begin
				for (int i = 0; i < ELEMS; i++) begin
					l_q[i] <= (i == 0 || i == 4 || i == 8) ?
						(WORD_W'(1) << FRAC_BITS) : '0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign last      = out_last_q;

	// a compose or transform beat starts the program
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_COMPOSE || op == OP_XFORM) |=> running)
		else $error("program did not start");

	// nothing is taken while earlier steps are still in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !v_s1 && !fire_s2 && !running)
		else $error("item accepted while datapath busy");

	// the last program step ends the run
	a_stop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		running && en && ctl.stop |=> !running)
		else $error("sequencer ran past its final step");

	// a last beat only comes from a step that stopped the program
	a_last_src: assert property (@(posedge clk) disable iff (!arst_n)
		en && fire_s2 && last_s2 |-> !running && !v_s1)
		else $error("last beat with steps still pending");

endmodule
